/* rtl/core/hmpt2m_pkg.sv */
// Shared types and constants for the HMP track to MIDI stream converter.
`timescale 1ns / 1ps

package hmpt2m_pkg;

  localparam int unsigned MaxVlqBytes = 4;
  localparam int unsigned CountW      = 31;

  localparam logic [CountW-1:0] CountMax = '1;

  localparam logic [7:0] MetaPrefix   = 8'hFF;
  localparam logic [7:0] EndOfTrack   = 8'h2F;
  localparam logic [7:0] SysStatusMin = 8'hF0;
  localparam logic [3:0] ProgChange   = 4'hC;
  localparam logic [3:0] ChanPressure = 4'hD;

  typedef enum logic [1:0] {
    KIND_BYTE  = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_ERROR = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
  } result_t;

endpackage

/* rtl/core/hmp_track_to_midi_stream_unit.sv */
// HMP track body to Standard MIDI track body converter, one input byte per beat.
//
//  channel  | dir | tdata                                   | tuser    | tlast
//  s_axis   | in  | [7:0] in_byte                           | -        | track_last
//  m_axis   | out | [7:0] out_byte, [38:8] track_length     | [1:0] kind | run_last
//
//  Each accepted byte is decoded in its accept cycle and its results (up to
//  max(MAX_VLQ_BYTES,2)) load a result bank drained one per beat. A byte with
//  at most one result lets the next enter as it leaves, so such bytes flow at
//  one per cycle when the output is not stalled; the last byte of an N-septet
//  delta holds the input until its N results drain, and the end marker's last
//  byte until its two do. Reset clears all control state; no clearing pass.
`timescale 1ns / 1ps

module hmp_track_to_midi_stream_unit #(
  parameter int unsigned MAX_VLQ_BYTES = hmpt2m_pkg::MaxVlqBytes
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] in_byte
  input  logic        s_axis_tlast_i,   // track_last
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,   // [7:0] out_byte, [38:8] track_length, [39] zero
  output logic [1:0]  m_axis_tuser_o,   // [1:0] kind
  output logic        m_axis_tlast_o    // run_last
);

  localparam int unsigned CntW = $clog2(MAX_VLQ_BYTES + 1);
  localparam int unsigned IdxW = (MAX_VLQ_BYTES > 1) ? $clog2(MAX_VLQ_BYTES) : 1;
  localparam int unsigned ResN = (MAX_VLQ_BYTES > 2) ? MAX_VLQ_BYTES : 2;
  localparam int unsigned ResW = $clog2(ResN + 1);
  localparam int unsigned RdW  = $clog2(ResN);
  localparam int unsigned CW   = hmpt2m_pkg::CountW;

  localparam logic [2:0] PhDelta    = 3'd0;
  localparam logic [2:0] PhStatus   = 3'd1;
  localparam logic [2:0] PhMetaType = 3'd2;
  localparam logic [2:0] PhMetaLen  = 3'd3;
  localparam logic [2:0] PhMetaData = 3'd4;
  localparam logic [2:0] PhChanData = 3'd5;
  localparam logic [2:0] PhSkip     = 3'd6;

  logic [2:0]  phase_q, phase_d;
  logic [6:0]  sept_q [MAX_VLQ_BYTES];
  logic [6:0]  sept_v [MAX_VLQ_BYTES];
  logic        sept_we;
  logic [CntW-1:0] dcnt_q, dcnt_d, dcnt_new;
  logic [7:0]  rs_q, rs_d;
  logic [7:0]  mkind_q, mkind_d;
  logic [27:0] mrem_q, mrem_d, mrem_new, mrem_dec;
  logic [CntW-1:0] mlen_q, mlen_d, mlen_new;
  logic [1:0]  drem_q, drem_d, drem_dec;
  logic [CW-1:0] ecnt_q, ecnt_d;

  hmpt2m_pkg::result_t res_q [ResN];
  hmpt2m_pkg::result_t res_d [ResN];
  hmpt2m_pkg::result_t cur;
  logic [CW-1:0] len_q, len_d;
  logic [ResW-1:0] rem_q, nres;
  logic [RdW-1:0]  rd_q;

  logic [7:0] b;
  logic       last, full, err, done, dovf, accept, take;

  assign b      = s_axis_tdata_i;
  assign last   = s_axis_tlast_i;
  assign full   = (ecnt_q == hmpt2m_pkg::CountMax);
  assign dcnt_new = dcnt_q + CntW'(1);
  assign dovf   = ({1'b0, ecnt_q} + 32'(dcnt_new)) > {1'b0, hmpt2m_pkg::CountMax};
  assign mrem_new = {mrem_q[20:0], b[6:0]};
  assign mrem_dec = (mrem_q != '0) ? mrem_q - 28'd1 : '0;
  assign mlen_new = mlen_q + CntW'(1);
  assign drem_dec = (drem_q != '0) ? drem_q - 2'd1 : '0;

  always_comb begin
    for (int j = 0; j < MAX_VLQ_BYTES; j++) begin
      sept_v[j] = (IdxW'(j) == dcnt_q[IdxW-1:0]) ? b[6:0] : sept_q[j];
    end
  end

  always_comb begin
    phase_d = phase_q;
    dcnt_d  = dcnt_q;
    rs_d    = rs_q;
    mkind_d = mkind_q;
    mrem_d  = mrem_q;
    mlen_d  = mlen_q;
    drem_d  = drem_q;
    ecnt_d  = ecnt_q;
    len_d   = '0;
    sept_we = 1'b0;
    err     = 1'b0;
    done    = 1'b0;
    nres    = '0;
    for (int i = 0; i < ResN; i++) begin
      res_d[i].kind = hmpt2m_pkg::KIND_BYTE;
      res_d[i].data = '0;
    end

    unique case (phase_q)
      PhDelta: begin
        if (dcnt_q >= CntW'(MAX_VLQ_BYTES)) begin
          err = 1'b1;
        end else begin
          sept_we = 1'b1;
          dcnt_d  = dcnt_new;
          if (last) begin
            err = 1'b1;
          end else if (!b[7]) begin
            if (dcnt_new >= CntW'(MAX_VLQ_BYTES)) err = 1'b1;
          end else if (dovf) begin
            err = 1'b1;
          end else begin
            for (int i = 0; i < MAX_VLQ_BYTES; i++) begin
              if (CntW'(i) < dcnt_new) begin
                res_d[i].data = {(CntW'(i) + CntW'(1) < dcnt_new),
                                 sept_v[IdxW'(dcnt_new - CntW'(i) - CntW'(1))]};
              end
            end
            nres    = ResW'(dcnt_new);
            ecnt_d  = ecnt_q + CW'(dcnt_new);
            dcnt_d  = '0;
            phase_d = PhStatus;
          end
        end
      end
      PhStatus: begin
        if (b == hmpt2m_pkg::MetaPrefix) begin
          if (last || full) begin
            err = 1'b1;
          end else begin
            res_d[0].data = b;
            nres    = ResW'(1);
            ecnt_d  = ecnt_q + CW'(1);
            phase_d = PhMetaType;
          end
        end else if (!b[7] || b >= hmpt2m_pkg::SysStatusMin || last) begin
          err = 1'b1;
        end else begin
          drem_d = (b[7:4] == hmpt2m_pkg::ProgChange ||
                    b[7:4] == hmpt2m_pkg::ChanPressure) ? 2'd1 : 2'd2;
          if (b != rs_q) begin
            if (full) begin
              err = 1'b1;
            end else begin
              res_d[0].data = b;
              nres   = ResW'(1);
              ecnt_d = ecnt_q + CW'(1);
            end
          end
          rs_d    = b;
          phase_d = PhChanData;
        end
      end
      PhMetaType: begin
        if (last || full) begin
          err = 1'b1;
        end else begin
          res_d[0].data = b;
          nres    = ResW'(1);
          ecnt_d  = ecnt_q + CW'(1);
          mkind_d = b;
          mrem_d  = '0;
          mlen_d  = '0;
          phase_d = PhMetaLen;
        end
      end
      PhMetaLen: begin
        mrem_d = mrem_new;
        mlen_d = mlen_new;
        res_d[0].data = b;
        nres   = ResW'(1);
        ecnt_d = ecnt_q + CW'(1);
        if (full) begin
          err = 1'b1;
        end else if (b[7]) begin
          if (last || mlen_new >= CntW'(MAX_VLQ_BYTES)) err = 1'b1;
        end else if (mkind_q == hmpt2m_pkg::EndOfTrack) begin
          if (mrem_new != '0 || !last) begin
            err = 1'b1;
          end else begin
            done          = 1'b1;
            res_d[1].kind = hmpt2m_pkg::KIND_DONE;
            nres          = ResW'(2);
            len_d         = ecnt_q + CW'(1);
          end
        end else if (last) begin
          err = 1'b1;
        end else begin
          phase_d = (mrem_new == '0) ? PhDelta : PhMetaData;
        end
      end
      PhMetaData: begin
        if (full || last) begin
          err = 1'b1;
        end else begin
          res_d[0].data = b;
          nres   = ResW'(1);
          ecnt_d = ecnt_q + CW'(1);
          mrem_d = mrem_dec;
          if (mrem_dec == '0) phase_d = PhDelta;
        end
      end
      PhChanData: begin
        if (full || last) begin
          err = 1'b1;
        end else begin
          res_d[0].data = b;
          nres   = ResW'(1);
          ecnt_d = ecnt_q + CW'(1);
          drem_d = drem_dec;
          if (drem_dec == '0) phase_d = PhDelta;
        end
      end
      default: begin
        // skipping to the end of a failed track
      end
    endcase

    if (err) begin
      res_d[0].kind = hmpt2m_pkg::KIND_ERROR;
      res_d[0].data = '0;
      nres          = ResW'(1);
      phase_d       = PhSkip;
    end

    if ((phase_q >= PhSkip || err || done) && last) begin
      phase_d = PhDelta;
      dcnt_d  = '0;
      rs_d    = '0;
      mkind_d = '0;
      mrem_d  = '0;
      mlen_d  = '0;
      drem_d  = '0;
      ecnt_d  = '0;
    end
  end

  assign s_axis_tready_o = (rem_q == '0) || (rem_q == ResW'(1) && m_axis_tready_i);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign m_axis_tvalid_o = (rem_q != '0);
  assign take            = m_axis_tvalid_o && m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhDelta;
      dcnt_q  <= '0;
      rs_q    <= '0;
      mkind_q <= '0;
      mrem_q  <= '0;
      mlen_q  <= '0;
      drem_q  <= '0;
      ecnt_q  <= '0;
      rem_q   <= '0;
      rd_q    <= '0;
    end else begin
      if (accept) begin
        phase_q <= phase_d;
        dcnt_q  <= dcnt_d;
        rs_q    <= rs_d;
        mkind_q <= mkind_d;
        mrem_q  <= mrem_d;
        mlen_q  <= mlen_d;
        drem_q  <= drem_d;
        ecnt_q  <= ecnt_d;
        rem_q   <= nres;
        rd_q    <= '0;
      end else if (take) begin
        rem_q <= rem_q - ResW'(1);
        rd_q  <= rd_q + RdW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && sept_we) begin
      sept_q[dcnt_q[IdxW-1:0]] <= b[6:0];
    end
    if (accept) begin
      res_q <= res_d;
      len_q <= len_d;
    end
  end

  assign cur             = res_q[rd_q];
  assign m_axis_tuser_o  = cur.kind;
  assign m_axis_tdata_o  = {1'b0,
                            (cur.kind == hmpt2m_pkg::KIND_DONE) ? len_q : {CW{1'b0}},
                            cur.data};
  assign m_axis_tlast_o  = (rem_q == ResW'(1));

endmodule
